[rtl/caa_pkg.sv]
// Shared types, constants and codes for the compacting arena allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package caa_pkg;

    localparam int ARENA_WORDS = 256;
    localparam int AW          = $clog2(ARENA_WORDS);
    localparam int PW          = AW + 2;
    localparam int TOP_INDEX   = ARENA_WORDS - 1;
    localparam int HDR_WORDS   = 3;
    localparam int FREED_BIT   = 16;
    localparam int MAX_RELOC   = 63;
    localparam int RELOC_W     = 6;
    localparam int ALU_W       = 35;
    localparam int BYTE_W      = 10;
    localparam int NWORDS_W    = BYTE_W - 1;
    localparam int NEED_W      = NWORDS_W + 1;
    localparam int CMP_W       = 9;

    localparam logic [2:0] REQ_ALLOC    = 3'd0;
    localparam logic [2:0] REQ_FREE     = 3'd1;
    localparam logic [2:0] REQ_FREE_ALL = 3'd2;
    localparam logic [2:0] REQ_READ     = 3'd3;
    localparam logic [2:0] REQ_WRITE    = 3'd4;

    localparam logic [2:0] KIND_GRANT = 3'd0;
    localparam logic [2:0] KIND_FAIL  = 3'd1;
    localparam logic [2:0] KIND_RELOC = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [9:0]  byte_count;
        logic [15:0] owner_handle;
        logic [15:0] caller_id;
        logic [7:0]  word_addr;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  block_addr;
        logic [15:0] owner_out;
        logic [31:0] read_word;
        logic        last;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DEC,
        S_AL_CHK,
        S_SL_LOOP,
        S_SL_LEN,
        S_SL_OWN,
        S_SL_WHO,
        S_SL_WR0,
        S_SL_WR1,
        S_SL_WR2,
        S_SL_CP,
        S_SL_BP,
        S_AL_RECHK,
        S_GR_H0,
        S_GR_H1,
        S_GR_H2,
        S_GR_BP,
        S_GR_ZF,
        S_FR_CHK,
        S_FR_SET,
        S_FA_LOOP,
        S_FA_WHO,
        S_FA_OWN,
        S_FA_LEN,
        S_RD,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/compacting_arena_allocator_core.sv]
// Top level of the compacting arena allocator: sequencer, arena store and compare unit.
// Depends on caa_pkg, caa_mem and caa_alu.
`timescale 1ns / 1ps
`default_nettype none
// A request beat is taken when start is high and busy is low; busy then stays high
// until the last result beat of that request is issued. Results appear on o_res for
// exactly one cycle each, flagged by o_strobe, and cannot be held off. Every step goes
// through the single arena port pair (one read, one write a cycle) and one shared
// subtract/compare unit. An alloc that fits zero-fills its data words, one word per cycle.
// An alloc that runs short first slides live blocks toward the top, with one relocation
// beat per moved block (at most 63). The arena reads as all zero after reset without any
// clearing pass.
module compacting_arena_allocator_core
    import caa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    input  wire logic i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    output logic      o_strobe,
    output t_res      o_res
);

    localparam logic signed [PW-1:0] P_HDR = PW'(HDR_WORDS);
    localparam logic signed [PW-1:0] P_ONE = PW'(1);
    localparam logic signed [PW-1:0] P_TWO = PW'(2);
    localparam logic signed [PW-1:0] P_TOP = PW'(TOP_INDEX);

    t_state r_state, n_state;
    t_req   r_req;
    logic [AW-1:0] r_top, n_top;
    logic [7:0]    r_floor;
    logic signed [PW-1:0] r_p, n_p, r_w, n_w, r_pn, n_pn;
    logic [31:0]   r_len, n_len, r_own, n_own, r_who, n_who;
    logic [AW-1:0] r_nhdr, n_nhdr;
    logic [AW:0]   r_cnt, n_cnt;
    logic          r_cpv, n_cpv, r_match, n_match;
    logic [RELOC_W-1:0] r_nrel, n_nrel;
    logic          r_strobe, n_strobe;
    t_res          r_res, n_res;

    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [31:0]   m_wdata, m_rdata;

    logic signed [ALU_W-1:0] a_a, a_b, a_diff;
    logic          a_lt;

    logic [NWORDS_W-1:0] nwords;
    logic [NEED_W-1:0]   need;
    logic          hdr_neg, free_ok, addr_in, back_ok;
    logic signed [PW-1:0] w_hdr;

    caa_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    caa_alu u_alu (
        .i_a    (a_a),
        .i_b    (a_b),
        .o_diff (a_diff),
        .o_lt   (a_lt)
    );

    // Round bytes up to whole words; a block also holds header and back pointer.
    assign nwords  = NWORDS_W'((11'(r_req.byte_count) + 11'd3) >> 2);
    assign need    = NEED_W'(nwords) + NEED_W'(HDR_WORDS + 1);
    assign hdr_neg = (r_p < P_HDR);
    assign free_ok = (CMP_W'(r_req.word_addr) > CMP_W'(r_top))
                  && (CMP_W'(r_req.word_addr) < CMP_W'(TOP_INDEX));
    assign addr_in = (CMP_W'(r_req.word_addr) < CMP_W'(ARENA_WORDS));
    assign back_ok = a_lt && (m_rdata <= 32'(TOP_INDEX - HDR_WORDS));
    assign w_hdr   = r_w - P_HDR;
    assign busy    = (r_state != S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (start) n_state = S_DEC;
            S_DEC: begin
                unique case (r_req.req_type)
                    REQ_ALLOC:    n_state = r_req.caller_id[0] ? S_IDLE : S_AL_CHK;
                    REQ_FREE:     n_state = free_ok ? S_FR_CHK : S_DONE;
                    REQ_FREE_ALL: n_state = S_FA_LOOP;
                    REQ_READ:     n_state = S_RD;
                    default:      n_state = S_DONE;
                endcase
            end
            S_AL_CHK:   n_state = a_lt ? S_SL_LOOP : S_GR_H0;
            S_SL_LOOP:  n_state = (a_lt && !hdr_neg) ? S_SL_LEN : S_AL_RECHK;
            S_SL_LEN:   n_state = a_lt ? S_AL_RECHK : S_SL_OWN;
            S_SL_OWN:   n_state = S_SL_WHO;
            S_SL_WHO:   n_state = (r_own[FREED_BIT] || (r_w == r_p)) ? S_SL_LOOP : S_SL_WR0;
            S_SL_WR0:   n_state = S_SL_WR1;
            S_SL_WR1:   n_state = S_SL_WR2;
            S_SL_WR2:   n_state = S_SL_CP;
            S_SL_CP:    if ((r_cnt == '0) && !r_cpv) n_state = S_SL_BP;
            S_SL_BP:    n_state = S_SL_LOOP;
            S_AL_RECHK: n_state = a_lt ? S_IDLE : S_GR_H0;
            S_GR_H0:    n_state = S_GR_H1;
            S_GR_H1:    n_state = S_GR_H2;
            S_GR_H2:    n_state = S_GR_BP;
            S_GR_BP:    n_state = S_GR_ZF;
            S_GR_ZF:    if (r_cnt == '0) n_state = S_IDLE;
            S_FR_CHK:   n_state = back_ok ? S_FR_SET : S_DONE;
            S_FR_SET:   n_state = S_IDLE;
            S_FA_LOOP:  n_state = (a_lt && !hdr_neg) ? S_FA_WHO : S_DONE;
            S_FA_WHO:   n_state = S_FA_OWN;
            S_FA_OWN:   n_state = S_FA_LEN;
            S_FA_LEN:   n_state = S_FA_LOOP;
            S_RD:       n_state = S_IDLE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, arena port, compare operands and result beats.
    always_comb begin
        n_top    = r_top;
        n_p      = r_p;
        n_w      = r_w;
        n_pn     = r_pn;
        n_len    = r_len;
        n_own    = r_own;
        n_who    = r_who;
        n_nhdr   = r_nhdr;
        n_cnt    = r_cnt;
        n_cpv    = r_cpv;
        n_match  = r_match;
        n_nrel   = r_nrel;
        n_strobe = 1'b0;
        n_res    = '0;
        m_we     = 1'b0;
        m_waddr  = '0;
        m_wdata  = '0;
        m_raddr  = '0;
        a_a      = ALU_W'(r_top);
        a_b      = ALU_W'(r_p);
        unique case (r_state)
            S_DEC: begin
                unique case (r_req.req_type)
                    REQ_ALLOC: begin
                        if (r_req.caller_id[0]) begin
                            n_strobe      = 1'b1;
                            n_res.kind    = KIND_FAIL;
                            n_res.last    = 1'b1;
                        end
                        n_p    = P_TOP;
                        n_w    = P_TOP;
                        n_nrel = '0;
                    end
                    REQ_FREE:     m_raddr = AW'(r_req.word_addr - 8'd1);
                    REQ_FREE_ALL: n_p = P_TOP;
                    REQ_READ:     m_raddr = AW'(r_req.word_addr);
                    REQ_WRITE: begin
                        m_we    = addr_in;
                        m_waddr = AW'(r_req.word_addr);
                        m_wdata = r_req.write_data;
                    end
                    default: ;
                endcase
            end
            S_AL_CHK, S_AL_RECHK: begin
                // No room when top < floor + need.
                a_a = ALU_W'(r_top);
                a_b = ALU_W'(r_floor) + ALU_W'(need);
                if (r_state == S_AL_RECHK && a_lt) begin
                    n_strobe   = 1'b1;
                    n_res.kind = KIND_FAIL;
                    n_res.last = 1'b1;
                end
            end
            S_SL_LOOP: begin
                m_raddr = AW'(r_p - P_ONE);
                if (!(a_lt && !hdr_neg)) n_top = AW'(r_w);
            end
            S_SL_LEN: begin
                // Block must not reach below word zero.
                a_a   = ALU_W'(r_p);
                a_b   = ALU_W'(m_rdata) + ALU_W'(HDR_WORDS + 1);
                n_len = m_rdata;
                n_pn  = PW'(a_diff);
                m_raddr = AW'(r_p - P_HDR);
                if (a_lt) n_top = AW'(r_w);
            end
            S_SL_OWN: begin
                n_own   = m_rdata;
                m_raddr = AW'(r_p - P_TWO);
            end
            S_SL_WHO: begin
                n_who = m_rdata;
                if (r_own[FREED_BIT]) begin
                    n_p = r_pn;
                end else if (r_w == r_p) begin
                    n_p = r_pn;
                    n_w = r_pn;
                end
            end
            S_SL_WR0: begin
                m_we    = 1'b1;
                m_waddr = AW'(w_hdr);
                m_wdata = r_own;
                n_w     = w_hdr;
                n_nhdr  = AW'(w_hdr);
                if (r_nrel != RELOC_W'(MAX_RELOC)) begin
                    n_strobe         = 1'b1;
                    n_res.kind       = KIND_RELOC;
                    n_res.block_addr = 8'(AW'(w_hdr) - r_len[AW-1:0]);
                    n_res.owner_out  = r_own[15:0];
                    n_nrel           = r_nrel + RELOC_W'(1);
                end
            end
            S_SL_WR1: begin
                m_we    = 1'b1;
                m_waddr = AW'(r_w + P_ONE);
                m_wdata = r_who;
            end
            S_SL_WR2: begin
                m_we    = 1'b1;
                m_waddr = AW'(r_w + P_TWO);
                m_wdata = r_len;
                n_p     = r_p - P_HDR;
                n_cnt   = r_len[AW:0];
                n_cpv   = 1'b0;
            end
            S_SL_CP: begin
                // Copy data words from the top down: read one ahead, write the word read last cycle.
                if (r_cpv) begin
                    m_we    = 1'b1;
                    m_waddr = AW'(r_w - P_ONE);
                    m_wdata = m_rdata;
                    n_w     = r_w - P_ONE;
                end
                m_raddr = AW'(r_p - P_ONE);
                if (r_cnt != '0) begin
                    n_p   = r_p - P_ONE;
                    n_cnt = r_cnt - 1'b1;
                    n_cpv = 1'b1;
                end else begin
                    n_cpv = 1'b0;
                end
            end
            S_SL_BP: begin
                m_we    = 1'b1;
                m_waddr = AW'(r_w - P_ONE);
                m_wdata = 32'(r_nhdr);
                n_w     = r_w - P_ONE;
                n_p     = r_p - P_ONE;
            end
            S_GR_H0: begin
                m_we    = 1'b1;
                m_waddr = r_top - AW'(HDR_WORDS);
                m_wdata = 32'(r_req.owner_handle);
            end
            S_GR_H1: begin
                m_we    = 1'b1;
                m_waddr = r_top - AW'(2);
                m_wdata = 32'(r_req.caller_id);
            end
            S_GR_H2: begin
                m_we    = 1'b1;
                m_waddr = r_top - AW'(1);
                m_wdata = 32'(nwords);
            end
            S_GR_BP: begin
                n_top   = AW'(NEED_W'(r_top) - need);
                m_we    = 1'b1;
                m_waddr = n_top;
                m_wdata = 32'(r_top - AW'(HDR_WORDS));
                n_cnt   = (AW + 1)'(nwords);
            end
            S_GR_ZF: begin
                if (r_cnt != '0) begin
                    m_we    = 1'b1;
                    m_waddr = r_top + r_cnt[AW-1:0];
                    n_cnt   = r_cnt - 1'b1;
                end else begin
                    n_strobe         = 1'b1;
                    n_res.kind       = KIND_GRANT;
                    n_res.block_addr = 8'(r_top + AW'(1));
                    n_res.owner_out  = r_req.owner_handle;
                    n_res.last       = 1'b1;
                end
            end
            S_FR_CHK: begin
                // Back pointer must name a header inside the live area.
                a_a     = ALU_W'(r_top);
                a_b     = ALU_W'(m_rdata);
                n_own   = m_rdata;
                m_raddr = m_rdata[AW-1:0];
            end
            S_FR_SET: begin
                m_we              = 1'b1;
                m_waddr           = r_own[AW-1:0];
                m_wdata           = m_rdata;
                m_wdata[FREED_BIT] = 1'b1;
                n_strobe          = 1'b1;
                n_res.kind        = KIND_DONE;
                n_res.last        = 1'b1;
            end
            S_FA_LOOP: m_raddr = AW'(r_p - P_TWO);
            S_FA_WHO: begin
                n_match = (m_rdata == 32'(r_req.caller_id));
                m_raddr = AW'(r_p - P_HDR);
            end
            S_FA_OWN: begin
                if (r_match) begin
                    m_we               = 1'b1;
                    m_waddr            = AW'(r_p - P_HDR);
                    m_wdata            = m_rdata;
                    m_wdata[FREED_BIT] = 1'b1;
                end
                m_raddr = AW'(r_p - P_ONE);
            end
            S_FA_LEN: begin
                // Step to the next block; a negative position ends the walk.
                a_a = ALU_W'(r_p - P_HDR);
                a_b = ALU_W'(m_rdata) + ALU_W'(1);
                n_p = a_lt ? -P_ONE : PW'(a_diff);
            end
            S_RD: begin
                n_strobe        = 1'b1;
                n_res.kind      = KIND_READ;
                n_res.read_word = addr_in ? m_rdata : 32'd0;
                n_res.last      = 1'b1;
            end
            S_DONE: begin
                n_strobe   = 1'b1;
                n_res.kind = KIND_DONE;
                n_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= AW'(TOP_INDEX);
            r_floor  <= 8'd0;
            r_strobe <= 1'b0;
            r_nrel   <= '0;
            r_cpv    <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_strobe <= n_strobe;
            r_nrel   <= n_nrel;
            r_cpv    <= n_cpv;
            r_cnt    <= n_cnt;
            if (i_cfg_we) r_floor <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) r_req <= i_req;
        r_p     <= n_p;
        r_w     <= n_w;
        r_pn    <= n_pn;
        r_len   <= n_len;
        r_own   <= n_own;
        r_who   <= n_who;
        r_nhdr  <= n_nhdr;
        r_match <= n_match;
        r_res   <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
`default_nettype wire

[rtl/caa_mem.sv]
// Arena word store: one write and one registered read per cycle.
// Per-word valid bits make unwritten words read as zero after reset. Uses caa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module caa_mem
    import caa_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);

    logic [31:0]          r_mem [ARENA_WORDS];
    logic [ARENA_WORDS-1:0] r_vld;
    logic [31:0]          r_q;
    logic                 r_qv;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_qv <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_qv ? r_q : 32'd0;

endmodule
`default_nettype wire

[rtl/caa_alu.sv]
// Shared signed subtract-and-compare unit used by the sequencer's compare and step states.
// Uses caa_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none
module caa_alu
    import caa_pkg::*;
(
    input  wire logic signed [ALU_W-1:0] i_a,
    input  wire logic signed [ALU_W-1:0] i_b,
    output logic signed [ALU_W-1:0]      o_diff,
    output logic                         o_lt
);

    assign o_diff = i_a - i_b;
    assign o_lt   = o_diff[ALU_W-1];

endmodule
`default_nettype wire

[rtl/caa_chk.sv]
// Port-level checker for the compacting arena allocator, bound to the top level.
// Uses caa_pkg for types and result codes.
`timescale 1ns / 1ps
`default_nettype none
module caa_chk
    import caa_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_strobe,
    input wire t_res o_res
);

    // An accepted request keeps the block busy and shows no beat the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_strobe)
        else $error("accept did not start a busy period");

    // A beat that is not the last one comes while the request is still in work.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |-> busy)
        else $error("non-final beat outside a request");

    // Relocation beats are never final.
    a_reloc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.kind == KIND_RELOC |-> !o_res.last)
        else $error("relocation marked last");

    // A final beat ends the request: the block is already idle when the beat appears.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.last |-> !busy)
        else $error("final beat while still busy");

endmodule

bind compacting_arena_allocator_core caa_chk u_caa_chk (.*);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for compacting_arena_allocator_core: random and directed requests,
// predicted against an in-bench arena model. Depends on caa_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import caa_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic o_strobe;
    t_res o_res;

    compacting_arena_allocator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_strobe(o_strobe), .o_res(o_res)
    );

    // Shadow copy of the arena, the allocation pointer and the floor register.
    logic [31:0] shadow_arena [0:ARENA_WORDS-1];
    int          shadow_top;
    int          shadow_floor;
    int          shadow_top_hint;

    t_req pending_reqs[$];
    t_res expected_beats[$];
    int   error_count;
    int   beats_seen;
    int   reqs_sent;
    int   send_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input t_res got, input t_res want);
        $display("MISMATCH %s at %0t: got k=%0d a=%0d o=%h w=%h l=%0d, want k=%0d a=%0d o=%h w=%h l=%0d",
                 what, $time, got.kind, got.block_addr, got.owner_out, got.read_word, got.last,
                 want.kind, want.block_addr, want.owner_out, want.read_word, want.last);
        error_count++;
    endtask

    function automatic t_res make_beat(logic [2:0] k, int a, logic [15:0] own, logic [31:0] w,
                                       logic l);
        t_res r;
        r.kind       = k;
        r.block_addr = a[7:0];
        r.owner_out  = own;
        r.read_word  = w;
        r.last       = l;
        return r;
    endfunction

    // Slide live blocks toward the top, queueing one relocation beat per moved block, up to MAX_RELOC.
    function automatic int compact_arena();
        longint p, w, hdr, span, new_hdr;
        logic [31:0] len, own, who;
        int moved;
        p = TOP_INDEX;
        w = TOP_INDEX;
        moved = 0;
        while (p > shadow_top) begin
            hdr = p - HDR_WORDS;
            if (hdr < 0) break;
            len  = shadow_arena[hdr + 2];
            span = longint'(len) + HDR_WORDS + 1;
            if (p - span < 0) break;
            own = shadow_arena[hdr];
            who = shadow_arena[hdr + 1];
            if (own[FREED_BIT]) begin
                p -= span;
                continue;
            end
            if (w == p) begin
                p -= span;
                w -= span;
                continue;
            end
            w -= HDR_WORDS;
            shadow_arena[w]     = own;
            shadow_arena[w + 1] = who;
            shadow_arena[w + 2] = len;
            new_hdr = w;
            if (moved < MAX_RELOC) begin
                expected_beats.push_back(make_beat(KIND_RELOC, int'(w - len), own[15:0], '0, 1'b0));
                moved++;
            end
            p = hdr;
            for (longint i = 0; i < len; i++) begin
                w--;
                p--;
                shadow_arena[w] = shadow_arena[p];
            end
            p--;
            w--;
            shadow_arena[w] = 32'(new_hdr);
        end
        shadow_top = int'(w);
        return moved;
    endfunction

    // Work out every result beat one accepted request causes, and advance the shadow state.
    task automatic predict_request(input t_req rq);
        int nwords, need, hdr, a;
        longint p, h, back;
        a = int'(rq.word_addr);
        case (rq.req_type)
            REQ_ALLOC: begin
                if (rq.caller_id[0]) begin
                    expected_beats.push_back(make_beat(KIND_FAIL, 0, '0, '0, 1'b1));
                    return;
                end
                nwords = (int'(rq.byte_count) + 3) >> 2;
                need   = nwords + HDR_WORDS + 1;
                if (shadow_top - shadow_floor < need) begin
                    void'(compact_arena());
                    if (shadow_top - shadow_floor < need) begin
                        expected_beats.push_back(make_beat(KIND_FAIL, 0, '0, '0, 1'b1));
                        return;
                    end
                end
                hdr = shadow_top - HDR_WORDS;
                shadow_arena[hdr]     = {16'h0, rq.owner_handle};
                shadow_arena[hdr + 1] = {16'h0, rq.caller_id};
                shadow_arena[hdr + 2] = 32'(nwords);
                shadow_top -= need;
                shadow_arena[shadow_top] = 32'(hdr);
                for (int i = 1; i <= nwords; i++) shadow_arena[shadow_top + i] = '0;
                expected_beats.push_back(make_beat(KIND_GRANT, shadow_top + 1, rq.owner_handle,
                                                   '0, 1'b1));
                return;
            end
            REQ_FREE: begin
                if (a > shadow_top && a < TOP_INDEX) begin
                    back = longint'(shadow_arena[a - 1]);
                    if (back > shadow_top && back + HDR_WORDS <= TOP_INDEX)
                        shadow_arena[back][FREED_BIT] = 1'b1;
                end
            end
            REQ_FREE_ALL: begin
                p = TOP_INDEX;
                while (p > shadow_top) begin
                    h = p - HDR_WORDS;
                    if (h < 0) break;
                    if (shadow_arena[h + 1] == {16'h0, rq.caller_id})
                        shadow_arena[h][FREED_BIT] = 1'b1;
                    p = h - longint'(shadow_arena[h + 2]) - 1;
                end
            end
            REQ_READ: begin
                expected_beats.push_back(make_beat(KIND_READ, 0, '0, shadow_arena[a], 1'b1));
                return;
            end
            REQ_WRITE: shadow_arena[a] = rq.write_data;
            default: ;
        endcase
        expected_beats.push_back(make_beat(KIND_DONE, 0, '0, '0, 1'b1));
    endtask

    // Driver: present queued beats at the falling edge, predict at the accepting edge.
    logic beat_accepted;
    always @(posedge i_clk) begin
        beat_accepted <= start && !busy && i_rst_n;
        if (start && !busy && i_rst_n) begin
            predict_request(i_req);
            reqs_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !beat_accepted) begin
            // Hold the beat until it is taken.
        end else if (pending_reqs.size() > 0 &&
                     $urandom_range(99, 0) >= send_idle_pct) begin
            i_req <= pending_reqs.pop_front();
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: results cannot be held off; compare each strobed beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat", o_res, '0);
            end else begin
                t_res want;
                want = expected_beats.pop_front();
                if (o_res.kind !== want.kind) report_mismatch("kind", o_res, want);
                else if (o_res.block_addr !== want.block_addr)
                    report_mismatch("block_addr", o_res, want);
                else if (o_res.owner_out !== want.owner_out)
                    report_mismatch("owner_out", o_res, want);
                else if (o_res.read_word !== want.read_word)
                    report_mismatch("read_word", o_res, want);
                else if (o_res.last !== want.last) report_mismatch("last", o_res, want);
            end
        end
    end

    function automatic t_req build_req(logic [2:0] op, int bytes, logic [15:0] own,
                                       logic [15:0] who, int a, logic [31:0] d);
        t_req r;
        r.req_type     = op;
        r.byte_count   = bytes[9:0];
        r.owner_handle = own;
        r.caller_id    = who;
        r.word_addr    = a[7:0];
        r.write_data   = d;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int pick;
        r = build_req(REQ_ALLOC, 0, 16'($urandom), 16'($urandom), int'($urandom_range(255, 0)),
                      $urandom);
        pick = $urandom_range(99, 0);
        // Mostly small even-caller allocs so the arena fills and compacts; a few big ones.
        if (pick < 40) begin
            r.req_type   = REQ_ALLOC;
            r.caller_id  = {13'h0, 3'($urandom_range(3, 0) * 2)};
            r.byte_count = (pick < 3) ? 10'($urandom_range(1023, 0)) : 10'($urandom_range(60, 0));
            if (pick == 39) r.caller_id[0] = 1'b1;
        end else if (pick < 62) begin
            r.req_type = REQ_FREE;
            if (pick < 55) r.word_addr = 8'($urandom_range(TOP_INDEX - 1, shadow_top_hint + 1));
        end else if (pick < 70) begin
            r.req_type  = REQ_FREE_ALL;
            r.caller_id = {13'h0, 3'($urandom_range(3, 0) * 2)};
        end else if (pick < 88) begin
            r.req_type = REQ_READ;
        end else if (pick < 95) begin
            // Writes land anywhere, headers included.
            r.req_type = REQ_WRITE;
        end else begin
            r.req_type = 3'($urandom_range(7, 5));
        end
        return r;
    endfunction

    always @(posedge i_clk) shadow_top_hint <= (shadow_top < 250) ? shadow_top : 200;

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || busy || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_floor(input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[7:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_floor = value;
    endtask

    initial begin
        int floors[4];
        floors = '{0, 255, 200, 0};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        error_count = 0;
        beats_seen = 0;
        reqs_sent = 0;
        send_idle_pct = 9;
        for (int i = 0; i < ARENA_WORDS; i++) shadow_arena[i] = '0;
        shadow_top = TOP_INDEX;
        shadow_floor = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every request kind, odd caller, full arena, bad frees.
        pending_reqs.push_back(build_req(REQ_READ, 0, 0, 0, 255, 0));
        pending_reqs.push_back(build_req(REQ_ALLOC, 0, 16'hFFFF, 16'hFFFE, 0, 0));
        pending_reqs.push_back(build_req(REQ_ALLOC, 5, 16'h1234, 16'h0001, 0, 0));
        pending_reqs.push_back(build_req(REQ_ALLOC, 8, 16'h00AA, 16'h0002, 0, 0));
        pending_reqs.push_back(build_req(REQ_ALLOC, 13, 16'h5555, 16'h0004, 0, 0));
        pending_reqs.push_back(build_req(REQ_WRITE, 0, 0, 0, 246, 32'hFFFF_FFFF));
        pending_reqs.push_back(build_req(REQ_READ, 0, 0, 0, 246, 0));
        pending_reqs.push_back(build_req(REQ_FREE, 0, 0, 0, 246, 0));
        pending_reqs.push_back(build_req(REQ_FREE, 0, 0, 0, 255, 0));
        pending_reqs.push_back(build_req(REQ_FREE, 0, 0, 0, 0, 0));
        pending_reqs.push_back(build_req(REQ_ALLOC, 1023, 16'h0F0F, 16'h0002, 0, 0));
        pending_reqs.push_back(build_req(REQ_FREE_ALL, 0, 0, 16'h0004, 0, 0));
        pending_reqs.push_back(build_req(REQ_ALLOC, 900, 16'hBEEF, 16'h0006, 0, 0));
        pending_reqs.push_back(build_req(REQ_ALLOC, 40, 16'h0001, 16'h0000, 0, 0));
        pending_reqs.push_back(build_req(3'd7, 1023, 16'hFFFF, 16'hFFFF, 255, 32'hFFFF_FFFF));
        pending_reqs.push_back(build_req(REQ_READ, 0, 0, 0, 0, 0));
        pending_reqs.push_back(build_req(REQ_WRITE, 0, 0, 0, 0, 32'h0000_0000));
        wait_drained();

        // Random phases under floors 0, 255, 200 and 0 again; switch idling halfway.
        for (int ph = 0; ph < 4; ph++) begin
            write_floor(floors[ph]);
            send_idle_pct = (ph < 2) ? 9 : ((ph == 2) ? 62 : 0);
            for (int n = 0; n < 45; n++) pending_reqs.push_back(random_req());
            wait_drained();
        end

        $display("Covered %0d requests and %0d result beats under floors 0, 200 and 255.",
                 reqs_sent, beats_seen);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/caa_pkg.sv
rtl/caa_mem.sv
rtl/caa_alu.sv
rtl/compacting_arena_allocator_core.sv
rtl/caa_chk.sv
tb/tb_top.sv
